// ===== design/act_pkg.sv =====
// Package with widths, pipeline depths and the arctangent table of the tilt-angle block.
package act_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int ANGLE_W         = 15;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STAGES   = 16;

    localparam int SQ_W            = 32;
    localparam int RAD_W           = 48;
    localparam int ROOT_W          = 24;
    localparam int REM_W           = 27;
    localparam int SQRT_PER_STAGE  = 2;
    localparam int SQRT_STAGES     = ROOT_W / SQRT_PER_STAGE;

    localparam int CW              = 27;
    localparam int ZW              = 29;
    localparam int ACC_FRAC        = 20;
    localparam int TABLE_LEN       = 25;

    // Input register, squares, then the per-axis pipeline: sum, root, rotations, rounding.
    localparam int LATENCY         = 2 + 1 + SQRT_STAGES + CORDIC_STAGES + 1;

    localparam logic signed [ZW-1:0] FULL_ANGLE =
        ZW'(90 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [ZW-1:0] ROUND_HALF =
        ZW'(1 << (ACC_FRAC - 1 - ANGLE_FRAC_BITS));
    localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;

    // atan(2^-i) in degrees with 20 fraction bits.
    localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
        29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121, 29'sd3750058,
        29'sd1876857, 29'sd938658, 29'sd469357, 29'sd234682, 29'sd117342,
        29'sd58671, 29'sd29335, 29'sd14668, 29'sd7334, 29'sd3667,
        29'sd1833, 29'sd917, 29'sd458, 29'sd229, 29'sd115,
        29'sd57, 29'sd29, 29'sd14, 29'sd7, 29'sd4
    };

endpackage

// ===== design/act_axis.sv =====
// One axis of the tilt pipeline: sum of squares, square root, vectoring rotations, rounding.
module act_axis (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [act_pkg::SAMPLE_W-1:0]   a,
    input  logic        [act_pkg::SQ_W-1:0]       sq_b,
    input  logic        [act_pkg::SQ_W-1:0]       sq_c,
    output logic signed [act_pkg::ANGLE_W-1:0]    angle
);
    import act_pkg::*;

    logic        [SQ_W-1:0]     sum_reg;
    logic signed [SAMPLE_W-1:0] a0_reg;

    logic        [RAD_W-1:0]    rad_reg  [SQRT_STAGES];
    logic        [REM_W-1:0]    rem_reg  [SQRT_STAGES];
    logic        [ROOT_W-1:0]   root_reg [SQRT_STAGES];
    logic signed [SAMPLE_W-1:0] sa_reg   [SQRT_STAGES];

    logic signed [CW-1:0]       x_reg    [CORDIC_STAGES];
    logic signed [CW-1:0]       y_reg    [CORDIC_STAGES];
    logic signed [ZW-1:0]       z_reg    [CORDIC_STAGES];
    logic signed [SAMPLE_W-1:0] ca_reg   [CORDIC_STAGES];
    logic                       zr_reg   [CORDIC_STAGES];

    logic signed [ANGLE_W-1:0]  angle_reg;
    logic signed [ANGLE_W-1:0]  angle_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sq_b + sq_c;
            a0_reg  <= a;
        end
    end

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++)
        begin : g_sqrt
            logic [RAD_W-1:0]  rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [RAD_W-1:0]  rad;
            logic [REM_W-1:0]  rem;
            logic [ROOT_W-1:0] root;
            logic [REM_W-1:0]  trial;
            logic signed [SAMPLE_W-1:0] a_in;

            if (k == 0)
            begin : g_first
                assign rad_in  = {sum_reg, {(RAD_W - SQ_W){1'b0}}};
                assign rem_in  = '0;
                assign root_in = '0;
                assign a_in    = a0_reg;
            end
            else
            begin : g_rest
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign a_in    = sa_reg[k-1];
            end

            // Two radicand bits per step; the remainder never exceeds twice the root.
            always_comb
            begin
                rad   = rad_in;
                rem   = rem_in;
                root  = root_in;
                trial = '0;
                for (int j = 0; j < SQRT_PER_STAGE; j++)
                begin
                    rem   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
                    trial = {1'b0, root, 2'b01};
                    if (rem >= trial)
                    begin
                        rem  = rem - trial;
                        root = {root[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        root = {root[ROOT_W-2:0], 1'b0};
                    end
                    rad = {rad[RAD_W-3:0], 2'b00};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= rad;
                    rem_reg[k]  <= rem;
                    root_reg[k] <= root;
                    sa_reg[k]   <= a_in;
                end
            end
        end
    endgenerate

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_cordic
            logic signed [CW-1:0]       x_in;
            logic signed [CW-1:0]       y_in;
            logic signed [ZW-1:0]       z_in;
            logic signed [SAMPLE_W-1:0] a_in;
            logic                       zr_in;
            logic signed [CW-1:0]       xs;
            logic signed [CW-1:0]       ys;

            if (i == 0)
            begin : g_first
                assign x_in  = CW'(root_reg[SQRT_STAGES-1]);
                assign y_in  = CW'(sa_reg[SQRT_STAGES-1]) <<< 8;
                assign z_in  = '0;
                assign a_in  = sa_reg[SQRT_STAGES-1];
                assign zr_in = (root_reg[SQRT_STAGES-1] == '0);
            end
            else
            begin : g_rest
                assign x_in  = x_reg[i-1];
                assign y_in  = y_reg[i-1];
                assign z_in  = z_reg[i-1];
                assign a_in  = ca_reg[i-1];
                assign zr_in = zr_reg[i-1];
            end

            assign xs = x_in >>> i;
            assign ys = y_in >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!y_in[CW-1])
                    begin
                        x_reg[i] <= x_in + ys;
                        y_reg[i] <= y_in - xs;
                        z_reg[i] <= z_in + ATAN_TAB[i];
                    end
                    else
                    begin
                        x_reg[i] <= x_in - ys;
                        y_reg[i] <= y_in + xs;
                        z_reg[i] <= z_in - ATAN_TAB[i];
                    end
                    ca_reg[i] <= a_in;
                    zr_reg[i] <= zr_in;
                end
            end
        end
    endgenerate

    // Round to the output resolution, saturate, and handle a zero root.
    always_comb
    begin
        logic signed [ZW-1:0] zf;
        logic signed [ZW-1:0] ang;
        logic signed [ZW-1:0] res;
        logic signed [SAMPLE_W-1:0] a_last;
        zf     = z_reg[CORDIC_STAGES-1] + ROUND_HALF;
        ang    = zf >>> ROUND_SHIFT;
        a_last = ca_reg[CORDIC_STAGES-1];
        if (ang > FULL_ANGLE)
            res = FULL_ANGLE;
        else if (ang < -FULL_ANGLE)
            res = -FULL_ANGLE;
        else
            res = ang;
        if (zr_reg[CORDIC_STAGES-1])
        begin
            if (a_last > 0)
                res = FULL_ANGLE;
            else if (a_last < 0)
                res = -FULL_ANGLE;
            else
                res = '0;
        end
        angle_next = res[ANGLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

// ===== design/accel_tilt_angles.sv =====
// Tilt angles of a three-axis accelerometer sample: pitch, roll and Z-axis inclination.
// The pipeline depth is act_pkg::LATENCY: input and square stages, one sum stage,
// twelve square-root stages of two root bits each, sixteen rotation stages, one rounding stage.
// Throughput is one request per cycle; the whole pipeline holds while a result is stalled.
// Reset clears the valid bits only; data registers are not reset.
module accel_tilt_angles (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [act_pkg::SAMPLE_W-1:0]   accel_x,
    input  logic signed [act_pkg::SAMPLE_W-1:0]   accel_y,
    input  logic signed [act_pkg::SAMPLE_W-1:0]   accel_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [act_pkg::ANGLE_W-1:0]    pitch_angle,
    output logic signed [act_pkg::ANGLE_W-1:0]    roll_angle,
    output logic signed [act_pkg::ANGLE_W-1:0]    z_tilt_angle,
    output logic                                  invalid
);
    import act_pkg::*;

    logic                       en;
    logic [LATENCY-1:0]         valid_reg;
    logic [LATENCY-1:0]         inv_reg;

    logic signed [SAMPLE_W-1:0] x_reg, y_reg, z_reg;
    logic signed [SAMPLE_W-1:0] xb_reg, yb_reg, zb_reg;
    logic        [SQ_W-1:0]     sqx_reg, sqy_reg, sqz_reg;

    assign en       = !(valid_reg[LATENCY-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LATENCY-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg <= {inv_reg[LATENCY-2:0],
                        (accel_x == '0) && (accel_y == '0) && (accel_z == '0)};
            x_reg   <= accel_x;
            y_reg   <= accel_y;
            z_reg   <= accel_z;
            xb_reg  <= x_reg;
            yb_reg  <= y_reg;
            zb_reg  <= z_reg;
            sqx_reg <= SQ_W'(x_reg) * SQ_W'(x_reg);
            sqy_reg <= SQ_W'(y_reg) * SQ_W'(y_reg);
            sqz_reg <= SQ_W'(z_reg) * SQ_W'(z_reg);
        end
    end

    act_axis u_pitch (
        .clk   (clk),
        .en    (en),
        .a     (xb_reg),
        .sq_b  (sqy_reg),
        .sq_c  (sqz_reg),
        .angle (pitch_angle)
    );

    act_axis u_roll (
        .clk   (clk),
        .en    (en),
        .a     (yb_reg),
        .sq_b  (sqx_reg),
        .sq_c  (sqz_reg),
        .angle (roll_angle)
    );

    act_axis u_ztilt (
        .clk   (clk),
        .en    (en),
        .a     (zb_reg),
        .sq_b  (sqx_reg),
        .sq_c  (sqy_reg),
        .angle (z_tilt_angle)
    );

    assign out_valid = valid_reg[LATENCY-1];
    assign invalid   = inv_reg[LATENCY-1];

endmodule
